[hw/rtl/triad_pkg.sv]
// shared types and constants of the triad frame unit
package triad_pkg;

	// width of every axis result port
	localparam int AXIS_W = 32;

	// magnitude width after block scaling (bit length 30, rounding may reach 2^30)
	localparam int SCALED_W = 31;

	// control that travels alongside each item in the datapath
	typedef struct packed {
		logic valid;
		logic degen;
	} triad_tag_t;

endpackage

[hw/rtl/triad_frame_from_two_vectors_unit.sv]
// top level: triad attitude frame from a primary and a secondary vector
// Takes one vector pair per clock whenever start is high; busy stays low, so every item
// offered is taken. The result for an item is marked by done for one cycle, and results
// come out in the order the items went in. The square root (31 stages) and the restoring
// divide (FRAC_BITS + 2 stages) of the normalisers work one bit per stage. The receiver
// cannot stall the block, so done must be caught when it comes. When the exact cross
// product is zero (a zero vector or parallel vectors), or that of the scaled vectors is,
// all nine axes are zero and degenerate is set.
module triad_frame_from_two_vectors_unit #(
	parameter int INPUT_BITS = 24,
	parameter int FRAC_BITS = 30
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  start,
	output logic                                  busy,
	input  logic signed [INPUT_BITS-1:0]          primary_x,
	input  logic signed [INPUT_BITS-1:0]          primary_y,
	input  logic signed [INPUT_BITS-1:0]          primary_z,
	input  logic signed [INPUT_BITS-1:0]          secondary_x,
	input  logic signed [INPUT_BITS-1:0]          secondary_y,
	input  logic signed [INPUT_BITS-1:0]          secondary_z,
	output logic                                  done,
	output logic signed [triad_pkg::AXIS_W-1:0]   xaxis_0,
	output logic signed [triad_pkg::AXIS_W-1:0]   xaxis_1,
	output logic signed [triad_pkg::AXIS_W-1:0]   xaxis_2,
	output logic signed [triad_pkg::AXIS_W-1:0]   yaxis_0,
	output logic signed [triad_pkg::AXIS_W-1:0]   yaxis_1,
	output logic signed [triad_pkg::AXIS_W-1:0]   yaxis_2,
	output logic signed [triad_pkg::AXIS_W-1:0]   zaxis_0,
	output logic signed [triad_pkg::AXIS_W-1:0]   zaxis_1,
	output logic signed [triad_pkg::AXIS_W-1:0]   zaxis_2,
	output logic                                  degenerate
);

	localparam int IB = INPUT_BITS;
	localparam int PW = 2 * IB;
	localparam int MW = triad_pkg::SCALED_W;
	localparam int LENW = 7;
	localparam int CW = 64;
	localparam int XW = FRAC_BITS + 2;
	localparam int YW = 2 * XW + 1;
	localparam logic [XW-1:0] ONE = XW'(1) << FRAC_BITS;

	function automatic logic [IB-1:0] mag_ib(input logic signed [IB-1:0] v);
		return v[IB-1] ? unsigned'(-v) : unsigned'(v);
	endfunction

	function automatic logic [LENW-1:0] bit_len(input logic [CW-1:0] v);
		logic [LENW-1:0] n;
		n = '0;
		for (int i = 0; i < CW; i++) begin
			if (v[i]) begin
				n = LENW'(i + 1);
			end
		end
		return n;
	endfunction

	// brings bit length len to 30: exact left shift, or right shift rounding half up
	function automatic logic [MW-1:0] bscale(input logic [CW-1:0] m, input logic [LENW-1:0] len);
		logic [CW+31:0] w;
		logic [CW+31:0] t;
		w = {m, 32'b0};
		t = (w >> len) + (CW+32)'(2);
		return t[MW+1:2];
	endfunction

	function automatic logic signed [31:0] to_sv(input logic [MW-1:0] m, input logic neg);
		logic signed [31:0] v;
		v = signed'({1'b0, m});
		return neg ? -v : v;
	endfunction

	// control pipeline
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8;

	// stage 1: captured inputs
	logic signed [IB-1:0] p_s1 [3];
	logic signed [IB-1:0] s_s1 [3];

	// stage 2: magnitudes, lengths, exact cross terms
	logic [IB-1:0]        pm_s2 [3];
	logic [IB-1:0]        sm_s2 [3];
	logic                 pn_s2 [3];
	logic                 sn_s2 [3];
	logic [LENW-1:0]      plen_s2;
	logic [LENW-1:0]      slen_s2;
	logic signed [PW-1:0] xp_s2 [6];

	// stage 3: block scaled vectors
	logic [MW-1:0] pmag_s3 [3];
	logic          pneg_s3 [3];
	logic [MW-1:0] smag_s3 [3];
	logic          sneg_s3 [3];
	logic          degx_s3;

	// stage 4: cross terms of the scaled vectors
	logic signed [CW-1:0] pc_s4 [6];
	logic [MW-1:0]        pmag_s4 [3];
	logic                 pneg_s4 [3];
	logic                 degx_s4;

	// stage 5: cross product magnitude
	logic [CW-1:0] cmag_s5 [3];
	logic          cneg_s5 [3];
	logic [MW-1:0] pmag_s5 [3];
	logic          pneg_s5 [3];
	logic          degen_s5;

	// stage 6: cross product length
	logic [CW-1:0]   cmag_s6 [3];
	logic            cneg_s6 [3];
	logic [LENW-1:0] clen_s6;
	logic [MW-1:0]   pmag_s6 [3];
	logic            pneg_s6 [3];
	logic            degen_s6;

	// stage 7: normaliser inputs
	logic [MW-1:0] cmag_s7 [3];
	logic          cneg_s7 [3];
	logic [MW-1:0] pmag_s7 [3];
	logic          pneg_s7 [3];
	logic          degen_s7;

	triad_pkg::triad_tag_t tag_s7;
	triad_pkg::triad_tag_t xtag;
	triad_pkg::triad_tag_t ztag;
	logic signed [XW-1:0]  xq [3];
	logic signed [XW-1:0]  zq [3];

	// stage 8: products for y = z cross x
	logic signed [2*XW-1:0] yp_s8 [6];
	logic signed [XW-1:0]   x_s8 [3];
	logic signed [XW-1:0]   z_s8 [3];
	logic                   degen_s8;

	logic signed [YW-1:0] w_c [3];
	logic [YW-1:0]        wm_c [3];
	logic [YW-1:0]        wr_c [3];
	logic [XW-1:0]        ym_c [3];
	logic signed [XW-1:0] y_c [3];

	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
			v_s8 <= 1'b0;
			done <= 1'b0;
		end else begin
			v_s1 <= start && !busy;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
			v_s8 <= xtag.valid && ztag.valid;
			done <= v_s8;
		end
	end

	always_ff @(posedge clk) begin
		p_s1[0] <= primary_x;
		p_s1[1] <= primary_y;
		p_s1[2] <= primary_z;
		s_s1[0] <= secondary_x;
		s_s1[1] <= secondary_y;
		s_s1[2] <= secondary_z;
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			pm_s2[i] <= mag_ib(p_s1[i]);
			sm_s2[i] <= mag_ib(s_s1[i]);
			pn_s2[i] <= p_s1[i][IB-1];
			sn_s2[i] <= s_s1[i][IB-1];
		end
		// length of the largest magnitude equals the length of their or
		plen_s2 <= bit_len(CW'(mag_ib(p_s1[0]) | mag_ib(p_s1[1]) | mag_ib(p_s1[2])));
		slen_s2 <= bit_len(CW'(mag_ib(s_s1[0]) | mag_ib(s_s1[1]) | mag_ib(s_s1[2])));
		xp_s2[0] <= PW'(p_s1[1]) * PW'(s_s1[2]);
		xp_s2[1] <= PW'(p_s1[2]) * PW'(s_s1[1]);
		xp_s2[2] <= PW'(p_s1[2]) * PW'(s_s1[0]);
		xp_s2[3] <= PW'(p_s1[0]) * PW'(s_s1[2]);
		xp_s2[4] <= PW'(p_s1[0]) * PW'(s_s1[1]);
		xp_s2[5] <= PW'(p_s1[1]) * PW'(s_s1[0]);
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			pmag_s3[i] <= bscale(CW'(pm_s2[i]), plen_s2);
			smag_s3[i] <= bscale(CW'(sm_s2[i]), slen_s2);
			pneg_s3[i] <= pn_s2[i];
			sneg_s3[i] <= sn_s2[i];
		end
		degx_s3 <= (xp_s2[0] == xp_s2[1]) && (xp_s2[2] == xp_s2[3])
			&& (xp_s2[4] == xp_s2[5]);
	end

	always_ff @(posedge clk) begin
		pc_s4[0] <= CW'(to_sv(pmag_s3[1], pneg_s3[1])) * CW'(to_sv(smag_s3[2], sneg_s3[2]));
		pc_s4[1] <= CW'(to_sv(pmag_s3[2], pneg_s3[2])) * CW'(to_sv(smag_s3[1], sneg_s3[1]));
		pc_s4[2] <= CW'(to_sv(pmag_s3[2], pneg_s3[2])) * CW'(to_sv(smag_s3[0], sneg_s3[0]));
		pc_s4[3] <= CW'(to_sv(pmag_s3[0], pneg_s3[0])) * CW'(to_sv(smag_s3[2], sneg_s3[2]));
		pc_s4[4] <= CW'(to_sv(pmag_s3[0], pneg_s3[0])) * CW'(to_sv(smag_s3[1], sneg_s3[1]));
		pc_s4[5] <= CW'(to_sv(pmag_s3[1], pneg_s3[1])) * CW'(to_sv(smag_s3[0], sneg_s3[0]));
		pmag_s4 <= pmag_s3;
		pneg_s4 <= pneg_s3;
		degx_s4 <= degx_s3;
	end

	always_ff @(posedge clk) begin
		logic signed [CW-1:0] c;
		logic                 cz;
		cz = 1'b1;
		for (int i = 0; i < 3; i++) begin
			c = pc_s4[2*i] - pc_s4[2*i+1];
			cmag_s5[i] <= c[CW-1] ? unsigned'(-c) : unsigned'(c);
			cneg_s5[i] <= c[CW-1];
			if (c != '0) begin
				cz = 1'b0;
			end
		end
		degen_s5 <= degx_s4 || cz;
		pmag_s5 <= pmag_s4;
		pneg_s5 <= pneg_s4;
	end

	always_ff @(posedge clk) begin
		clen_s6 <= bit_len(cmag_s5[0] | cmag_s5[1] | cmag_s5[2]);
		cmag_s6 <= cmag_s5;
		cneg_s6 <= cneg_s5;
		pmag_s6 <= pmag_s5;
		pneg_s6 <= pneg_s5;
		degen_s6 <= degen_s5;
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			cmag_s7[i] <= bscale(cmag_s6[i], clen_s6);
		end
		cneg_s7 <= cneg_s6;
		pmag_s7 <= pmag_s6;
		pneg_s7 <= pneg_s6;
		degen_s7 <= degen_s6;
	end

	assign tag_s7 = '{valid: v_s7, degen: degen_s7};

	triad_norm #(
		.FRAC_BITS(FRAC_BITS)
	) u_norm_x (
		.clk     (clk),
		.arst_n  (arst_n),
		.tag_in  (tag_s7),
		.mag_in  (pmag_s7),
		.neg_in  (pneg_s7),
		.tag_out (xtag),
		.q_out   (xq)
	);

	triad_norm #(
		.FRAC_BITS(FRAC_BITS)
	) u_norm_z (
		.clk     (clk),
		.arst_n  (arst_n),
		.tag_in  (tag_s7),
		.mag_in  (cmag_s7),
		.neg_in  (cneg_s7),
		.tag_out (ztag),
		.q_out   (zq)
	);

	always_ff @(posedge clk) begin
		yp_s8[0] <= (2*XW)'(zq[1]) * (2*XW)'(xq[2]);
		yp_s8[1] <= (2*XW)'(zq[2]) * (2*XW)'(xq[1]);
		yp_s8[2] <= (2*XW)'(zq[2]) * (2*XW)'(xq[0]);
		yp_s8[3] <= (2*XW)'(zq[0]) * (2*XW)'(xq[2]);
		yp_s8[4] <= (2*XW)'(zq[0]) * (2*XW)'(xq[1]);
		yp_s8[5] <= (2*XW)'(zq[1]) * (2*XW)'(xq[0]);
		x_s8 <= xq;
		z_s8 <= zq;
		degen_s8 <= xtag.degen || ztag.degen;
	end

	// y magnitude rounded half up after the shift back to q1 format, then clamped
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			w_c[i] = YW'(yp_s8[2*i]) - YW'(yp_s8[2*i+1]);
			wm_c[i] = w_c[i][YW-1] ? unsigned'(-w_c[i]) : unsigned'(w_c[i]);
			wr_c[i] = (wm_c[i] + (YW'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
			ym_c[i] = (wr_c[i] > YW'(ONE)) ? ONE : wr_c[i][XW-1:0];
			y_c[i] = w_c[i][YW-1] ? -$signed(ym_c[i]) : $signed(ym_c[i]);
		end
	end

	always_ff @(posedge clk) begin
		degenerate <= degen_s8;
		if (degen_s8) begin
			xaxis_0 <= '0;
			xaxis_1 <= '0;
			xaxis_2 <= '0;
			yaxis_0 <= '0;
			yaxis_1 <= '0;
			yaxis_2 <= '0;
			zaxis_0 <= '0;
			zaxis_1 <= '0;
			zaxis_2 <= '0;
		end else begin
			xaxis_0 <= triad_pkg::AXIS_W'(x_s8[0]);
			xaxis_1 <= triad_pkg::AXIS_W'(x_s8[1]);
			xaxis_2 <= triad_pkg::AXIS_W'(x_s8[2]);
			yaxis_0 <= triad_pkg::AXIS_W'(y_c[0]);
			yaxis_1 <= triad_pkg::AXIS_W'(y_c[1]);
			yaxis_2 <= triad_pkg::AXIS_W'(y_c[2]);
			zaxis_0 <= triad_pkg::AXIS_W'(z_s8[0]);
			zaxis_1 <= triad_pkg::AXIS_W'(z_s8[1]);
			zaxis_2 <= triad_pkg::AXIS_W'(z_s8[2]);
		end
	end

endmodule

[hw/rtl/triad_norm.sv]
// triad_norm: pipelined vector normaliser, integer square root then restoring divide
module triad_norm #(
	parameter int FRAC_BITS = 30
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  triad_pkg::triad_tag_t           tag_in,
	input  logic [triad_pkg::SCALED_W-1:0]  mag_in [3],
	input  logic                            neg_in [3],
	output triad_pkg::triad_tag_t           tag_out,
	output logic signed [FRAC_BITS+1:0]     q_out [3]
);

	localparam int MW = triad_pkg::SCALED_W;
	localparam int SQW = 2 * MW;
	localparam int NW = SQW + 2;
	localparam int SQ_STEPS = SQW / 2;
	localparam int RW = MW + 1;
	localparam int QW = FRAC_BITS + 2;
	localparam int DW = MW + FRAC_BITS + 3;
	localparam int P = SQ_STEPS + 3;
	localparam int LAST = P + QW + 1;
	localparam logic [QW-1:0] ONE = QW'(1) << FRAC_BITS;

	triad_pkg::triad_tag_t tag_s [LAST+1];
	logic                  neg_s [LAST][3];
	logic [MW-1:0]         mag_s [P][3];

	logic [SQW-1:0] sq_s1 [3];
	logic [NW-1:0]  sq_rem [SQ_STEPS+1];
	logic [NW-1:0]  sq_root [SQ_STEPS+1];

	logic [RW-1:0] dv_div [QW+1];
	logic [DW-1:0] dv_rem [QW+1][3];
	logic [QW-1:0] dv_q [QW+1][3];

	logic [QW-1:0] qc [3];

	assign tag_s[0] = tag_in;
	assign neg_s[0] = neg_in;
	assign mag_s[0] = mag_in;
	assign tag_out = tag_s[LAST];

	for (genvar e = 1; e <= LAST; e++) begin : g_tag
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				tag_s[e] <= '0;
			end else begin
				tag_s[e] <= tag_s[e-1];
			end
		end
	end

	for (genvar e = 1; e < LAST; e++) begin : g_neg
		always_ff @(posedge clk) begin
			neg_s[e] <= neg_s[e-1];
		end
	end

	for (genvar e = 1; e < P; e++) begin : g_mag
		always_ff @(posedge clk) begin
			mag_s[e] <= mag_s[e-1];
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			sq_s1[i] <= SQW'(mag_in[i]) * SQW'(mag_in[i]);
		end
	end

	always_ff @(posedge clk) begin
		sq_rem[0] <= NW'(sq_s1[0]) + NW'(sq_s1[1]) + NW'(sq_s1[2]);
		sq_root[0] <= '0;
	end

	// one root bit per stage
	for (genvar k = 0; k < SQ_STEPS; k++) begin : g_sqrt
		localparam logic [NW-1:0] BIT = NW'(1) << (SQW - 2 - 2 * k);
		logic [NW-1:0] trial;
		assign trial = sq_root[k] + BIT;
		always_ff @(posedge clk) begin
			if (sq_rem[k] >= trial) begin
				sq_rem[k+1] <= sq_rem[k] - trial;
				sq_root[k+1] <= (sq_root[k] >> 1) + BIT;
			end else begin
				sq_rem[k+1] <= sq_rem[k];
				sq_root[k+1] <= sq_root[k] >> 1;
			end
		end
	end

	// numerator carries half the divisor for round half up
	always_ff @(posedge clk) begin
		dv_div[0] <= sq_root[SQ_STEPS][RW-1:0];
		for (int i = 0; i < 3; i++) begin
			dv_rem[0][i] <= (DW'(mag_s[P-1][i]) << FRAC_BITS)
				+ DW'(sq_root[SQ_STEPS][RW-1:1]);
			dv_q[0][i] <= '0;
		end
	end

	// one quotient bit per stage, msb first
	for (genvar m = 0; m < QW; m++) begin : g_div
		localparam int J = QW - 1 - m;
		logic [DW-1:0] dsh;
		assign dsh = DW'(dv_div[m]) << J;
		always_ff @(posedge clk) begin
			dv_div[m+1] <= dv_div[m];
			for (int i = 0; i < 3; i++) begin
				if (dv_rem[m][i] >= dsh) begin
					dv_rem[m+1][i] <= dv_rem[m][i] - dsh;
					dv_q[m+1][i] <= {dv_q[m][i][QW-2:0], 1'b1};
				end else begin
					dv_rem[m+1][i] <= dv_rem[m][i];
					dv_q[m+1][i] <= {dv_q[m][i][QW-2:0], 1'b0};
				end
			end
		end
	end

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			qc[i] = (dv_q[QW][i] > ONE) ? ONE : dv_q[QW][i];
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			q_out[i] <= neg_s[LAST-1][i] ? -$signed(qc[i]) : $signed(qc[i]);
		end
	end

endmodule

[tb/tb_triad_frame_from_two_vectors_unit.sv]
// testbench of the triad frame unit: random and directed vector pairs checked against a predictor
`timescale 1ns / 1ps
module tb_triad_frame_from_two_vectors_unit;

	localparam int IN_W = 24;
	localparam int FRAC = 30;
	localparam int LATENCY = FRAC + 45;
	localparam int CYCLE_LIMIT = 200000;
	localparam int N_RANDOM = 530;

	typedef struct {
		logic signed [IN_W-1:0] p [3];
		logic signed [IN_W-1:0] s [3];
		bit drain;
	} vec_pair_t;

	typedef struct {
		logic signed [31:0] ax [9];
		logic degen;
	} frame_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	logic signed [IN_W-1:0] primary_x = '0, primary_y = '0, primary_z = '0;
	logic signed [IN_W-1:0] secondary_x = '0, secondary_y = '0, secondary_z = '0;
	logic done, degenerate;
	logic signed [31:0] xaxis_0, xaxis_1, xaxis_2, yaxis_0, yaxis_1, yaxis_2;
	logic signed [31:0] zaxis_0, zaxis_1, zaxis_2;

	vec_pair_t pending_items [$];
	frame_t expected_frames [$];
	int accepted_cnt = 0;
	int sent_cnt = 0;
	int gap_left = 0;
	int failures = 0;
	int frames_seen = 0;
	int degen_seen = 0;
	int cycles = 0;

	triad_frame_from_two_vectors_unit dut (.*);

	always #5 clk = ~clk;

	function automatic longint unsigned mag(longint v);
		return v < 0 ? longint'(0) - v : v;
	endfunction

	function automatic void block_scale(input longint v [3], output longint u [3]);
		longint unsigned top, m;
		int len;
		top = 0;
		len = 0;
		for (int i = 0; i < 3; i++)
			if (mag(v[i]) > top) top = mag(v[i]);
		for (longint unsigned t = top; t != 0; t >>= 1) len++;
		for (int i = 0; i < 3; i++) begin
			m = mag(v[i]);
			if (len == 0) m = 0;
			else if (len < 30) m = m << (30 - len);
			else if (len > 30) m = (m + (64'd1 << (len - 31))) >> (len - 30);
			u[i] = v[i] < 0 ? -longint'(m) : longint'(m);
		end
	endfunction

	function automatic longint unsigned int_sqrt(longint unsigned n);
		longint unsigned r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > n) b >>= 2;
		while (b != 0) begin
			if (n >= r + b) begin
				n -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	function automatic void cross3(input longint a [3], input longint b [3],
			output longint c [3]);
		c[0] = a[1] * b[2] - a[2] * b[1];
		c[1] = a[2] * b[0] - a[0] * b[2];
		c[2] = a[0] * b[1] - a[1] * b[0];
	endfunction

	function automatic void unit_vec(input longint v [3], output longint q [3]);
		longint u [3];
		longint unsigned n2, r, a, qq;
		block_scale(v, u);
		n2 = 0;
		for (int i = 0; i < 3; i++) n2 += mag(u[i]) * mag(u[i]);
		r = int_sqrt(n2);
		for (int i = 0; i < 3; i++) begin
			if (r == 0) begin
				q[i] = 0;
			end else begin
				a = mag(u[i]) << FRAC;
				qq = (a + r / 2) / r;
				if (qq > (64'd1 << FRAC)) qq = 64'd1 << FRAC;
				q[i] = u[i] < 0 ? -longint'(qq) : longint'(qq);
			end
		end
	endfunction

	function automatic frame_t triad_frame(vec_pair_t it);
		frame_t f;
		longint p [3], s [3], ps [3], ss [3], c [3], x [3], y [3], z [3], w [3];
		longint unsigned m;
		bit dg;
		for (int i = 0; i < 3; i++) begin
			p[i] = longint'(it.p[i]);
			s[i] = longint'(it.s[i]);
		end
		dg = (p[1] * s[2] == p[2] * s[1]) && (p[2] * s[0] == p[0] * s[2]) &&
			(p[0] * s[1] == p[1] * s[0]);
		block_scale(p, ps);
		block_scale(s, ss);
		cross3(ps, ss, c);
		if (c[0] == 0 && c[1] == 0 && c[2] == 0) dg = 1'b1;
		f.degen = dg;
		if (dg) begin
			for (int i = 0; i < 9; i++) f.ax[i] = '0;
			return f;
		end
		unit_vec(p, x);
		unit_vec(c, z);
		cross3(z, x, w);
		for (int i = 0; i < 3; i++) begin
			m = (mag(w[i]) + (64'd1 << (FRAC - 1))) >> FRAC;
			if (m > (64'd1 << FRAC)) m = 64'd1 << FRAC;
			y[i] = w[i] < 0 ? -longint'(m) : longint'(m);
			f.ax[i] = x[i][31:0];
			f.ax[3 + i] = y[i][31:0];
			f.ax[6 + i] = z[i][31:0];
		end
		return f;
	endfunction

	task automatic add_pair(longint px, longint py, longint pz, longint sx, longint sy,
			longint sz, bit drain = 1'b0);
		vec_pair_t it;
		it.p[0] = IN_W'(px); it.p[1] = IN_W'(py); it.p[2] = IN_W'(pz);
		it.s[0] = IN_W'(sx); it.s[1] = IN_W'(sy); it.s[2] = IN_W'(sz);
		it.drain = drain;
		pending_items.push_back(it);
	endtask

	function automatic longint rnd_full();
		return longint'($signed(24'($urandom)));
	endfunction

	function automatic longint rnd_span(int lim);
		return longint'($urandom_range(2 * lim)) - lim;
	endfunction

	// driver: holds an item until it is taken, then waits its drawn gap
	always @(negedge clk) begin
		if (arst_n) begin
			if (start && accepted_cnt != sent_cnt) begin
				// still waiting on acceptance of the current item
			end else if (gap_left > 0) begin
				gap_left <= gap_left - 1;
				start <= 1'b0;
			end else if (pending_items.size() != 0 &&
					!(pending_items[0].drain && expected_frames.size() != 0)) begin
				vec_pair_t it;
				it = pending_items.pop_front();
				primary_x <= it.p[0]; primary_y <= it.p[1]; primary_z <= it.p[2];
				secondary_x <= it.s[0]; secondary_y <= it.s[1]; secondary_z <= it.s[2];
				start <= 1'b1;
				sent_cnt <= sent_cnt + 1;
				// long runs without idling alternate with stretches of random gaps
				gap_left <= ((cycles / 300) % 3 == 0) ? 0 : $urandom_range(16);
			end else begin
				start <= 1'b0;
			end
		end
	end

	// monitor: predicts on acceptance and checks each done strobe
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (arst_n && start && !busy) begin
			vec_pair_t it;
			it.p[0] = primary_x; it.p[1] = primary_y; it.p[2] = primary_z;
			it.s[0] = secondary_x; it.s[1] = secondary_y; it.s[2] = secondary_z;
			expected_frames.push_back(triad_frame(it));
			accepted_cnt <= accepted_cnt + 1;
		end
		if (arst_n && done) begin
			frame_t e;
			logic signed [31:0] got [9];
			got = '{xaxis_0, xaxis_1, xaxis_2, yaxis_0, yaxis_1, yaxis_2,
				zaxis_0, zaxis_1, zaxis_2};
			frames_seen <= frames_seen + 1;
			if (expected_frames.size() == 0) begin
				$error("result with no item waiting");
				failures = failures + 1;
			end else begin
				e = expected_frames.pop_front();
				if (e.degen) degen_seen <= degen_seen + 1;
				if (degenerate !== e.degen) begin
					$error("degenerate: expected %0d actual %0d", e.degen, degenerate);
					failures = failures + 1;
				end
				for (int i = 0; i < 9; i++)
					if (got[i] !== e.ax[i]) begin
						$error("%s_%0d: expected %0d actual %0d",
							i < 3 ? "xaxis" : (i < 6 ? "yaxis" : "zaxis"), i % 3,
							e.ax[i], got[i]);
						failures = failures + 1;
					end
			end
		end
		if (cycles >= CYCLE_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	initial begin
		longint px, py, pz, k;
		// extremes and special cases
		add_pair(-8388608, -8388608, -8388608, 8388607, 8388607, -8388608);
		add_pair(8388607, 8388607, 8388607, -8388608, 0, 8388607);
		add_pair(0, 0, 0, 5, 7, 9);
		add_pair(3, 4, 5, 0, 0, 0);
		add_pair(0, 0, 0, 0, 0, 0);
		add_pair(2, 4, 6, 4, 8, 12);
		add_pair(2, 4, 6, -1, -2, -3);
		add_pair(1, 0, 0, 0, 1, 0);
		add_pair(0, 0, -1, -1, 0, 0);
		add_pair(-8388608, 0, 0, 0, 8388607, 0);
		add_pair(1, 1, 1, 1, 1, 0);
		add_pair(-1, -1, -1, 8388607, -8388608, 1);
		add_pair(8388607, 8388606, 1, 8388606, 8388607, -1);
		add_pair(-8388608, -8388608, 0, 8388607, 8388607, 1);
		add_pair(8388607, 1, 0, 8388607, 2, 0);
		add_pair(1, 2, 3, 3, 2, 1, 1'b1);
		add_pair(-8388608, 8388607, -8388608, 8388607, -8388608, 8388607);
		add_pair(123456, -654321, 7, -8388608, 8388607, 0);
		for (int n = 0; n < N_RANDOM; n++) begin
			case ($urandom_range(9))
				0: add_pair(0, 0, 0, rnd_full(), rnd_full(), rnd_full());
				1: begin
					// parallel or antiparallel pair
					px = rnd_span(2047); py = rnd_span(2047); pz = rnd_span(2047);
					k = rnd_span(4095);
					add_pair(px, py, pz, px * k, py * k, pz * k);
				end
				2: add_pair(rnd_span(8), rnd_span(8), rnd_span(8),
					rnd_span(8), rnd_span(8), rnd_span(8));
				3: begin
					// nearly parallel pair
					px = rnd_span(1000000); py = rnd_span(1000000); pz = rnd_span(1000000);
					add_pair(px, py, pz, px + rnd_span(2), py + rnd_span(2), pz);
				end
				4: add_pair(rnd_span(1000), rnd_full(), rnd_span(3),
					rnd_full(), rnd_span(1000), rnd_full());
				default: add_pair(rnd_full(), rnd_full(), rnd_full(),
					rnd_full(), rnd_full(), rnd_full(), n % 200 == 199);
			endcase
		end
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		wait (pending_items.size() == 0 && accepted_cnt == sent_cnt && !start);
		wait (expected_frames.size() == 0);
		repeat (LATENCY + 20) @(posedge clk);
		$display("covered %0d vector pairs, %0d frames checked, %0d of them degenerate",
			accepted_cnt, frames_seen, degen_seen);
		if (failures == 0 && expected_frames.size() == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule

[filelist.f]
hw/rtl/triad_pkg.sv
hw/rtl/triad_norm.sv
hw/rtl/triad_frame_from_two_vectors_unit.sv
tb/tb_triad_frame_from_two_vectors_unit.sv
